/* rtl/core/date_add_subtract_days_assert.svh */
// Assertion macros for the date add/subtract block checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef DATE_ADD_SUBTRACT_DAYS_ASSERT_SVH
`define DATE_ADD_SUBTRACT_DAYS_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define DASD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dasd assertion failed");

// Check a consequence in the cycle after its trigger
`define DASD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dasd assertion failed");

`endif

/* rtl/core/dasd_pkg.sv */
// Shared types, constants and calendar helpers for the date add/subtract block.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package dasd_pkg;

  // Channel widths, fields packed from bit 0 and padded to whole bytes
  localparam int IN_TDATA_W  = 40;  // year 12, month 4, day 5, day count 16
  localparam int OUT_TDATA_W = 24;  // year 12, month 4, day 5
  localparam int YEAR_W      = 12;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int COUNT_W     = 16;
  localparam int M400_W      = 9;

  // Command codes carried on in_tuser
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUB = 1'b1;

  // Calendar constants
  localparam logic [YEAR_W-1:0]  YEAR_LOW  = 12'd1970;
  localparam logic [YEAR_W-1:0]  YEAR_END  = 12'd3000;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [M400_W-1:0]  M400_LAST = 9'd399;

  // Length of a month; only February depends on the leap flag
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Year modulo 400 by a short chain of conditional subtracts
  function automatic logic [M400_W-1:0] year_mod400(input logic [YEAR_W-1:0] year);
    logic [YEAR_W-1:0] r;
    r = year;
    if (r >= 12'd3200) r = r - 12'd3200;
    if (r >= 12'd1600) r = r - 12'd1600;
    if (r >= 12'd800)  r = r - 12'd800;
    if (r >= 12'd400)  r = r - 12'd400;
    return r[M400_W-1:0];
  endfunction

  // Gregorian leap test from the low year bits and the year modulo 400
  function automatic logic leap_of(input logic [1:0] year_lo,
                                   input logic [M400_W-1:0] m400);
    return (year_lo == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200) && (m400 != 9'd300);
  endfunction

endpackage

/* rtl/core/date_add_subtract_days.sv */
// Top level of the Gregorian date add/subtract block.
// Depends on dasd_pkg for widths, command codes and calendar helpers.
`timescale 1ns / 1ps

// Moves a Gregorian date forward (in_tuser = 0) or backward (in_tuser = 1) by a
// day count, walking one month per clock through a single compare-and-subtract
// unit. A transaction is loaded, its year reduced and its start date set up
// before the walk, then the result waits on the output until taken. in_tready
// is low from acceptance until the result transaction completes. Invalid
// starting dates and walks that leave years 1970..2999 give out_tuser = 1 with
// an all-zero date. Only the low COUNT_BITS bits of the day count are used.
module date_add_subtract_days #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [11:0] start_year, [15:12] start_month, [20:16] start_day, [36:21] day_count
  input  logic [dasd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] command
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [11:0] result_year, [15:12] result_month, [20:16] result_day
  output logic [dasd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] out_of_range
  output logic                              out_tuser
);
  import dasd_pkg::*;

  localparam int ACC_W = COUNT_BITS + 1;
  localparam int EXT_W = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SETUP,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    cmd_r, cmd_nxt;
  logic [YEAR_W-1:0]       year_r, year_nxt;
  logic [MONTH_W-1:0]      month_r, month_nxt;
  logic [DAY_W-1:0]        op_r, op_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [M400_W-1:0]       m400_r, m400_nxt;
  logic                    leap_r, leap_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic                    out_tuser_r, out_tuser_nxt;

  logic [EXT_W-1:0]        count_ext;
  logic [ACC_W-1:0]        count_in;
  logic                    start_leap;
  logic [DAY_W-1:0]        start_len;
  logic                    start_ok;
  logic                    is_sub;
  logic [ACC_W-1:0]        op_ext;
  logic                    take;
  logic                    wrap;
  logic [MONTH_W-1:0]      month_step;
  logic [YEAR_W-1:0]       year_step;
  logic [M400_W-1:0]       m400_step;
  logic                    leap_step;
  logic                    bound_hit;
  logic [DAY_W-1:0]        final_day;

  // Keep only the low COUNT_BITS bits of the incoming day count
  assign count_ext = EXT_W'(in_tdata[36:21]);
  assign count_in  = ACC_W'(count_ext[COUNT_BITS-1:0]);

  // Validate the starting date once the year residue is known
  assign start_leap = leap_of(year_r[1:0], m400_r);
  assign start_len  = days_in(month_r, start_leap);
  assign start_ok   = (year_r >= YEAR_LOW) && (year_r < YEAR_END) &&
                      (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC) &&
                      (op_r != '0) && (op_r <= start_len);

  // Shared compare-subtract unit and one-month step
  assign is_sub     = (cmd_r == CMD_SUB);
  assign op_ext     = ACC_W'(op_r);
  assign take       = is_sub ? (acc_r >= op_ext) : (acc_r > op_ext);
  assign wrap       = is_sub ? (month_r == MONTH_JAN) : (month_r == MONTH_DEC);
  assign month_step = wrap ? (is_sub ? MONTH_DEC : MONTH_JAN)
                           : (is_sub ? month_r - 4'd1 : month_r + 4'd1);
  assign year_step  = is_sub ? year_r - 12'd1 : year_r + 12'd1;
  assign m400_step  = is_sub ? ((m400_r == '0) ? M400_LAST : m400_r - 9'd1)
                             : ((m400_r == M400_LAST) ? '0 : m400_r + 9'd1);
  assign leap_step  = leap_of(year_step[1:0], m400_step);
  assign bound_hit  = wrap && (is_sub ? (year_step < YEAR_LOW) : (year_step >= YEAR_END));
  assign final_day  = is_sub ? op_r - acc_r[DAY_W-1:0] : acc_r[DAY_W-1:0];

  // Sequence one transaction: load, reduce year, set up, walk, deliver
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    year_nxt       = year_r;
    month_nxt      = month_r;
    op_nxt         = op_r;
    acc_nxt        = acc_r;
    m400_nxt       = m400_r;
    leap_nxt       = leap_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          year_nxt  = in_tdata[11:0];
          month_nxt = in_tdata[15:12];
          op_nxt    = in_tdata[20:16];
          acc_nxt   = count_in;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        m400_nxt  = year_mod400(year_r);
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (!start_ok) begin
          out_tdata_nxt  = '0;
          out_tuser_nxt  = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          leap_nxt = start_leap;
          // Adding folds the start day into the count and compares to the month length
          if (!is_sub) begin
            acc_nxt = acc_r + op_ext;
            op_nxt  = start_len;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (take) begin
          acc_nxt   = acc_r - op_ext;
          month_nxt = month_step;
          op_nxt    = days_in(month_step, wrap ? leap_step : leap_r);
          if (wrap) begin
            year_nxt = year_step;
            m400_nxt = m400_step;
            leap_nxt = leap_step;
          end
          if (bound_hit) begin
            out_tdata_nxt  = '0;
            out_tuser_nxt  = 1'b1;
            out_tvalid_nxt = 1'b1;
            state_nxt      = ST_DONE;
          end
        end else begin
          out_tdata_nxt  = OUT_TDATA_W'({final_day, month_r, year_r});
          out_tuser_nxt  = 1'b0;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_tready) begin
          out_tvalid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, working registers and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r       <= cmd_nxt;
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    op_r        <= op_nxt;
    acc_r       <= acc_nxt;
    m400_r      <= m400_nxt;
    leap_r      <= leap_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* rtl/core/dasd_checker.sv */
// Port-level checker for the date add/subtract block, bound to the top level.
// Depends on dasd_pkg and the macros in date_add_subtract_days_assert.svh.
`timescale 1ns / 1ps
`include "date_add_subtract_days_assert.svh"

module dasd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dasd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser
);
  import dasd_pkg::*;

  // Hold a stalled result transaction
  `DASD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Drop ready once a transaction is taken
  `DASD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // Never take input while a result waits
  `DASD_ASSERT_SAME(a_one_in_flight, out_tvalid, !in_tready)

  // Zero the date on an out-of-range result
  `DASD_ASSERT_SAME(a_oor_zero, out_tvalid && out_tuser, out_tdata == '0)

  // Keep a good result inside the calendar
  `DASD_ASSERT_SAME(a_date_sane, out_tvalid && !out_tuser,
    (out_tdata[11:0] >= YEAR_LOW) && (out_tdata[11:0] < YEAR_END) &&
    (out_tdata[15:12] >= MONTH_JAN) && (out_tdata[15:12] <= MONTH_DEC) &&
    (out_tdata[20:16] != '0))

endmodule

bind date_add_subtract_days dasd_checker u_dasd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
